>>> hdl/lrp_pkg.sv
// Package for the log-return price path builder: widths, fixed-point constants,
// register indexes and the types shared by the front, queue and back modules.
// No dependencies.
package lrp_pkg;

   // Field widths
   localparam int RET_W   = 32;   // log return, signed Q3.28
   localparam int PRICE_W = 48;   // price, unsigned Q24.24
   localparam int DAYS_W  = 16;   // path length and day counter
   localparam int EXP_W   = 43;   // exp result, unsigned Q13.30
   localparam int EXP_FRAC = 30;  // fraction bits of the exp result

   // Series evaluation of exp(r)
   localparam int EXP_TERMS = 24;
   localparam logic [65:0] LN2_Q60 = 66'h0B17217F7D1CF79B;
   // Offset that makes the reduction remainder start non-negative (n starts at -12)
   localparam logic [65:0] LN2_X12 = LN2_Q60 * 66'd12;
   localparam logic [60:0] Q60_ONE = {1'b1, 60'b0};

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_PRICE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAYS_PER_PATH = 1'b1;

   // Reset values of the configuration registers
   localparam logic [PRICE_W-1:0] INITIAL_PRICE_RESET = 48'd16777216;
   localparam logic [DAYS_W-1:0]  DAYS_PER_PATH_RESET = 16'd252;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

   // Depth of the queue between front and back
   localparam int LRP_QUEUE_DEPTH = 2;

   typedef logic [PRICE_W-1:0] price_type;
   typedef logic [EXP_W-1:0]   exp_type;

   // Configuration seen by the back end
   typedef struct packed {
      price_type         initial_price;
      logic [DAYS_W-1:0] days_per_path;
   } cfg_type;

   // One exp value moving through the queue
   typedef struct packed {
      logic    valid;
      exp_type data;
   } exp_push_type;

endpackage

>>> hdl/log_return_price_path_builder.sv
// Top level of the log-return price path builder: configuration registers,
// exp front end, queue and price back end. Depends on lrp_pkg, lrp_exp_front,
// lrp_queue and lrp_price_back.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_log_return (signed Q3.28)
//   rsp_      out        rsp_valid/rsp_ready   rsp_price (Q24.24), rsp_saturated,
//                                              rsp_first_of_path, rsp_last_of_path
//   csr_      in         csr_we                csr_index, csr_wdata
//
// A request occupies the exp unit through accept, range reduction (n in -12..11),
// the multiply and divide steps of each of the 24 series terms, round and
// hand-off. The back end overlaps with the next request, so the series loop
// sets the throughput.
// Synchronous reset clears control state, the running price and the day count.
// A stalled response holds in its register; the queue lets the front end go on
// until it is full.
module log_return_price_path_builder import lrp_pkg::*; #(
   parameter int QUEUE_DEPTH = LRP_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [RET_W-1:0] req_log_return,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PRICE_W-1:0]      rsp_price,
   output logic                    rsp_saturated,
   output logic                    rsp_first_of_path,
   output logic                    rsp_last_of_path,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [PRICE_W-1:0]      csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   exp_push_type push;
   exp_push_type head;
   logic         push_full;
   logic         pop;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_PRICE: cfg_in.initial_price = csr_wdata;
            CSR_DAYS_PER_PATH: cfg_in.days_per_path = csr_wdata[DAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_price <= INITIAL_PRICE_RESET;
         cfg_ff.days_per_path <= DAYS_PER_PATH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lrp_exp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_log_return (req_log_return),
      .push           (push),
      .push_full      (push_full)
   );

   lrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (push_full),
      .head  (head),
      .pop   (pop)
   );

   lrp_price_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_price         (rsp_price),
      .rsp_saturated     (rsp_saturated),
      .rsp_first_of_path (rsp_first_of_path),
      .rsp_last_of_path  (rsp_last_of_path)
   );

endmodule

>>> hdl/lrp_exp_front.sv
// Front end: accepts log returns and evaluates exp() as unsigned Q13.30.
// Range reduction, a 24-term Taylor series on a shared 32x32 multiplier and
// a radix-256 divider by the term index. Depends on lrp_pkg.
module lrp_exp_front import lrp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [RET_W-1:0] req_log_return,
   output exp_push_type            push,
   input  logic                    push_full
);

   typedef enum logic [5:0] {
      F_IDLE   = 6'b000001,
      F_REDUCE = 6'b000010,
      F_MUL    = 6'b000100,
      F_DIV    = 6'b001000,
      F_ROUND  = 6'b010000,
      F_PUSH   = 6'b100000
   } front_state_type;

   // Shift of a partial product within the 120-bit accumulator
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_32 = 2'd1;
   localparam logic [1:0] SH_64 = 2'd2;

   localparam logic [2:0] MUL_LAST   = 3'd4;
   localparam logic [2:0] DIV_LAST   = 3'd7;
   localparam logic [5:0] SHIFT_BASE = 6'd42;   // 30 minus the lowest n of -12

   front_state_type state_ff, state_in;
   logic [65:0]     rem_ff, rem_in;
   logic [4:0]      nidx_ff, nidx_in;
   logic [60:0]     term_ff, term_in;
   logic [61:0]     sum_ff, sum_in;
   logic [4:0]      k_ff, k_in;
   logic [2:0]      mcnt_ff, mcnt_in;
   logic [63:0]     prod_ff, prod_in;
   logic [1:0]      psel_ff, psel_in;
   logic [119:0]    acc_ff, acc_in;
   logic [63:0]     dq_ff, dq_in;
   logic [4:0]      drem_ff, drem_in;
   logic [2:0]      dcnt_ff, dcnt_in;
   exp_type         e_ff, e_in;

   logic [31:0]  mul_a, mul_b;
   logic [1:0]   psel_now;
   logic [119:0] prod_shift;
   logic [119:0] acc_sum;
   logic [7:0]   div_q;
   logic [4:0]   div_r;
   logic [5:0]   div_rr;
   logic [63:0]  div_word;
   logic [5:0]   shamt;
   logic [62:0]  rnd;

   assign req_ready  = (state_ff == F_IDLE);
   assign push.valid = (state_ff == F_PUSH);
   assign push.data  = e_ff;

   // Partial product select: term x r in 32-bit halves
   always_comb begin
      case (mcnt_ff)
         3'd0: begin
            mul_a = term_ff[31:0];
            mul_b = rem_ff[31:0];
            psel_now = SH_0;
         end
         3'd1: begin
            mul_a = term_ff[31:0];
            mul_b = {4'b0, rem_ff[59:32]};
            psel_now = SH_32;
         end
         3'd2: begin
            mul_a = {3'b0, term_ff[60:32]};
            mul_b = rem_ff[31:0];
            psel_now = SH_32;
         end
         3'd3: begin
            mul_a = {3'b0, term_ff[60:32]};
            mul_b = {4'b0, rem_ff[59:32]};
            psel_now = SH_64;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            psel_now = SH_0;
         end
      endcase
   end

   // Align the registered partial product
   always_comb begin
      case (psel_ff)
         SH_0:    prod_shift = {56'b0, prod_ff};
         SH_32:   prod_shift = {24'b0, prod_ff, 32'b0};
         SH_64:   prod_shift = {prod_ff[55:0], 64'b0};
         default: prod_shift = '0;
      endcase
   end

   assign acc_sum = acc_ff + prod_shift;

   // Eight restoring steps per cycle; divisor k is at most 24
   always_comb begin
      div_r  = drem_ff;
      div_q  = '0;
      div_rr = '0;
      for (int j = 0; j < 8; j++) begin
         div_rr = {div_r, dq_ff[63-j]};
         if (div_rr >= {1'b0, k_ff}) begin
            div_r = 5'(div_rr - {1'b0, k_ff});
            div_q[7-j] = 1'b1;
         end else begin
            div_r = div_rr[4:0];
         end
      end
      div_word = {dq_ff[55:0], div_q};
   end

   // Final scaling by 2^n with round half up
   assign shamt = SHIFT_BASE - {1'b0, nidx_ff};
   assign rnd   = {1'b0, sum_ff} + (63'd1 << (shamt - 6'd1));

   // Sequencer
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      nidx_in  = nidx_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      k_in     = k_ff;
      mcnt_in  = mcnt_ff;
      prod_in  = prod_ff;
      psel_in  = psel_ff;
      acc_in   = acc_ff;
      dq_in    = dq_ff;
      drem_in  = drem_ff;
      dcnt_in  = dcnt_ff;
      e_in     = e_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               rem_in   = 66'($signed({req_log_return, 32'b0})) + LN2_X12;
               nidx_in  = '0;
               state_in = F_REDUCE;
            end
         end
         F_REDUCE: begin
            // Step n up until the remainder is below ln2
            if (rem_ff >= LN2_Q60) begin
               rem_in  = rem_ff - LN2_Q60;
               nidx_in = nidx_ff + 1'b1;
            end else begin
               term_in  = Q60_ONE;
               sum_in   = 62'(Q60_ONE);
               k_in     = 5'd1;
               mcnt_in  = '0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in = mul_a * mul_b;
            psel_in = psel_now;
            acc_in  = (mcnt_ff == 3'd0) ? '0 : acc_sum;
            if (mcnt_ff == MUL_LAST) begin
               dq_in    = {4'b0, acc_sum[119:60]};
               drem_in  = '0;
               dcnt_in  = '0;
               state_in = F_DIV;
            end else begin
               mcnt_in = mcnt_ff + 1'b1;
            end
         end
         F_DIV: begin
            dq_in   = div_word;
            drem_in = div_r;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) begin
               term_in = div_word[60:0];
               sum_in  = sum_ff + div_word[61:0];
               if (k_ff == 5'(EXP_TERMS)) begin
                  state_in = F_ROUND;
               end else begin
                  k_in     = k_ff + 1'b1;
                  mcnt_in  = '0;
                  state_in = F_MUL;
               end
            end
         end
         F_ROUND: begin
            e_in     = EXP_W'(rnd >> shamt);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!push_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      nidx_ff <= nidx_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      k_ff    <= k_in;
      mcnt_ff <= mcnt_in;
      prod_ff <= prod_in;
      psel_ff <= psel_in;
      acc_ff  <= acc_in;
      dq_ff   <= dq_in;
      drem_ff <= drem_in;
      dcnt_ff <= dcnt_in;
      e_ff    <= e_in;
   end

endmodule

>>> hdl/lrp_queue.sv
// Small flip-flop queue of exp values between front and back ends.
// Depends on lrp_pkg.
module lrp_queue import lrp_pkg::*; #(
   parameter int DEPTH = LRP_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  exp_push_type push,
   output logic         full,
   output exp_push_type head,
   input  logic         pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   exp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

>>> hdl/lrp_price_back.sv
// Back end: takes exp values from the queue, multiplies them into the running
// price, tracks the day within the path and holds the response register.
// Depends on lrp_pkg.
module lrp_price_back import lrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  exp_push_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output price_type    rsp_price,
   output logic         rsp_saturated,
   output logic         rsp_first_of_path,
   output logic         rsp_last_of_path
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_MUL  = 3'b010,
      B_FIN  = 3'b100
   } back_state_type;

   // Partial product alignment codes
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_22 = 2'd1;
   localparam logic [1:0] SH_24 = 2'd2;
   localparam logic [1:0] SH_46 = 2'd3;

   localparam logic [2:0]  MUL_LAST   = 3'd4;
   localparam logic [91:0] ROUND_HALF = 92'd1 << (EXP_FRAC - 1);

   back_state_type    state_ff, state_in;
   exp_type           ex_ff, ex_in;
   price_type         base_ff, base_in;
   logic              first_ff, first_in;
   logic [2:0]        mcnt_ff, mcnt_in;
   logic [45:0]       prod_ff, prod_in;
   logic [1:0]        psel_ff, psel_in;
   logic [90:0]       acc_ff, acc_in;
   price_type         running_ff, running_in;
   logic [DAYS_W-1:0] day_ff, day_in;
   logic              rsp_valid_ff, rsp_valid_in;
   price_type         price_ff, price_in;
   logic              sat_ff, sat_in;
   logic              fop_ff, fop_in;
   logic              lop_ff, lop_in;

   logic [23:0]       mul_a;
   logic [21:0]       mul_b;
   logic [1:0]        psel_now;
   logic [90:0]       prod_shift;
   logic [90:0]       acc_sum;
   logic [91:0]       rnd;
   logic [61:0]       pfull;
   logic              sat_new;
   price_type         price_new;
   logic [DAYS_W-1:0] day_inc;
   logic              last_new;
   logic              out_free;

   assign pop               = (state_ff == B_IDLE) && head.valid;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_price         = price_ff;
   assign rsp_saturated     = sat_ff;
   assign rsp_first_of_path = fop_ff;
   assign rsp_last_of_path  = lop_ff;

   // Partial product select: base in 24-bit halves, exp in 22/21-bit halves
   always_comb begin
      case (mcnt_ff)
         3'd0: begin
            mul_a = base_ff[23:0];
            mul_b = ex_ff[21:0];
            psel_now = SH_0;
         end
         3'd1: begin
            mul_a = base_ff[23:0];
            mul_b = {1'b0, ex_ff[42:22]};
            psel_now = SH_22;
         end
         3'd2: begin
            mul_a = base_ff[47:24];
            mul_b = ex_ff[21:0];
            psel_now = SH_24;
         end
         3'd3: begin
            mul_a = base_ff[47:24];
            mul_b = {1'b0, ex_ff[42:22]};
            psel_now = SH_46;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            psel_now = SH_0;
         end
      endcase
   end

   always_comb begin
      case (psel_ff)
         SH_0:    prod_shift = {45'b0, prod_ff};
         SH_22:   prod_shift = {23'b0, prod_ff, 22'b0};
         SH_24:   prod_shift = {21'b0, prod_ff, 24'b0};
         SH_46:   prod_shift = {prod_ff[44:0], 46'b0};
         default: prod_shift = '0;
      endcase
   end

   assign acc_sum = acc_ff + prod_shift;

   // Round Q37.54 to Q24.24, clamp, advance the day counter
   assign rnd       = {1'b0, acc_ff} + ROUND_HALF;
   assign pfull     = rnd[91:30];
   assign sat_new   = |pfull[61:48];
   assign price_new = sat_new ? PRICE_MAX : pfull[47:0];
   assign day_inc   = day_ff + 1'b1;
   assign last_new  = (day_inc >= cfg.days_per_path);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      ex_in        = ex_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      mcnt_in      = mcnt_ff;
      prod_in      = prod_ff;
      psel_in      = psel_ff;
      acc_in       = acc_ff;
      running_in   = running_ff;
      day_in       = day_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      price_in     = price_ff;
      sat_in       = sat_ff;
      fop_in       = fop_ff;
      lop_in       = lop_ff;
      case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               ex_in    = head.data;
               first_in = (day_ff == '0);
               base_in  = (day_ff == '0) ? cfg.initial_price : running_ff;
               mcnt_in  = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in = mul_a * mul_b;
            psel_in = psel_now;
            acc_in  = (mcnt_ff == 3'd0) ? '0 : acc_sum;
            if (mcnt_ff == MUL_LAST) begin
               state_in = B_FIN;
            end else begin
               mcnt_in = mcnt_ff + 1'b1;
            end
         end
         B_FIN: begin
            // Wait for the response register to free up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               price_in     = price_new;
               sat_in       = sat_new;
               fop_in       = first_ff;
               lop_in       = last_new;
               running_in   = price_new;
               day_in       = last_new ? '0 : day_inc;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         running_ff   <= '0;
         day_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         day_ff       <= day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_ff    <= ex_in;
      base_ff  <= base_in;
      first_ff <= first_in;
      mcnt_ff  <= mcnt_in;
      prod_ff  <= prod_in;
      psel_ff  <= psel_in;
      acc_ff   <= acc_in;
      price_ff <= price_in;
      sat_ff   <= sat_in;
      fop_ff   <= fop_in;
      lop_ff   <= lop_in;
   end

endmodule

>>> hdl/lrp_checker.sv
// Port-level checks for the log-return price path builder, bound to the top.
// Depends on lrp_pkg and log_return_price_path_builder.
module lrp_checker import lrp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PRICE_W-1:0] rsp_price,
   input logic               rsp_saturated,
   input logic               rsp_first_of_path,
   input logic               rsp_last_of_path
);

   // Last flag of the previous delivered response; reset starts a new path
   logic prev_last_ff, prev_last_in;

   assign prev_last_in = (rsp_valid && rsp_ready) ? rsp_last_of_path : prev_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
      end else begin
         prev_last_ff <= prev_last_in;
      end
   end

   // No response is shown right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_price)
         && $stable(rsp_saturated) && $stable(rsp_first_of_path)
         && $stable(rsp_last_of_path))
      else $error("stalled response changed");

   // A clamped price sits at full scale
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_price == PRICE_MAX)
      else $error("saturated price not at maximum");

   // A path starts exactly after the previous one ended
   a_path_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_of_path == prev_last_ff)
      else $error("first-of-path flag out of order");

endmodule

bind log_return_price_path_builder lrp_checker u_lrp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_price         (rsp_price),
   .rsp_saturated     (rsp_saturated),
   .rsp_first_of_path (rsp_first_of_path),
   .rsp_last_of_path  (rsp_last_of_path)
);
